// ===== rtl/brainwave_sensor_packet_parser_defines.svh =====
// Assertion helpers used by the parser's top-level RTL.
`ifndef BRAINWAVE_SENSOR_PACKET_PARSER_DEFINES_SVH
`define BRAINWAVE_SENSOR_PACKET_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BWPP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("parser check failed");

// Next-cycle implication, checked outside reset.
`define BWPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("parser check failed");

`endif

// ===== rtl/bwpp_pkg.sv =====
package bwpp_pkg;

  localparam int PAYLOAD_DEPTH_DEF = 256;

  localparam logic [7:0] SYNC_BYTE      = 8'hAA;
  localparam logic [7:0] CODE_QUALITY   = 8'h02;
  localparam logic [7:0] CODE_ATTENTION = 8'h04;
  localparam logic [7:0] CODE_MEDITATE  = 8'h05;
  localparam logic [7:0] CODE_BLINK     = 8'h16;
  localparam logic [7:0] CODE_RAW       = 8'h80;
  localparam logic [7:0] CODE_POWER     = 8'h83;

  localparam logic [7:0] RAW_LEN    = 8'd2;
  localparam logic [7:0] POWER_LEN  = 8'd24;
  localparam int         BAND_COUNT = 8;

  localparam logic [3:0] FID_QUALITY   = 4'd0;
  localparam logic [3:0] FID_ATTENTION = 4'd1;
  localparam logic [3:0] FID_MEDITATE  = 4'd2;
  localparam logic [3:0] FID_BLINK     = 4'd3;
  localparam logic [3:0] FID_RAW       = 4'd4;
  localparam logic [3:0] FID_BAND0     = 4'd5;
  localparam logic [3:0] FID_LAST      = 4'd12;

  typedef struct packed {
    logic [7:0]                   quality;
    logic [7:0]                   attention;
    logic [7:0]                   meditation;
    logic [7:0]                   blink;
    logic [15:0]                  raw;
    logic [BAND_COUNT-1:0][23:0]  band;
  } record_t;

endpackage

// ===== rtl/bwpp_row_walker.sv =====
module bwpp_row_walker #(
  parameter int PAYLOAD_DEPTH = bwpp_pkg::PAYLOAD_DEPTH_DEF,
  localparam int AW = $clog2(PAYLOAD_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [7:0]         wr_data,
  input  logic               start,
  input  logic [7:0]         len,
  output logic               done,
  output logic               att,
  output bwpp_pkg::record_t  rec
);

  typedef enum logic [3:0] {
    W_IDLE, W_CODE_RD, W_CODE, W_LEN_RD, W_LEN, W_CHECK, W_VAL_RD, W_VAL
  } wstate_t;

  wstate_t     state;
  logic [7:0]  mem [PAYLOAD_DEPTH];
  logic [7:0]  rd_data;
  logic [8:0]  pos;
  logic [8:0]  row_end;
  logic [7:0]  code;
  logic [7:0]  rlen;
  logic [4:0]  need;
  logic [4:0]  cnt;
  logic [1:0]  tri_cnt;
  logic [2:0]  band_idx;
  logic [15:0] acc;
  logic [8:0]  row_end_next;
  logic [8:0]  len_ext;

  assign len_ext      = 9'(len);
  assign row_end_next = pos + 9'(rlen);

  // Payload store: one write port from the receiver, one registered read.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[pos[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= W_IDLE;
      done     <= 1'b0;
      att      <= 1'b0;
      rec      <= '0;
      pos      <= '0;
      row_end  <= '0;
      code     <= '0;
      rlen     <= '0;
      need     <= '0;
      cnt      <= '0;
      tri_cnt  <= '0;
      band_idx <= '0;
      acc      <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        W_IDLE: begin
          if (start) begin
            pos   <= '0;
            att   <= 1'b0;
            state <= W_CODE_RD;
          end
        end
        W_CODE_RD: begin
          if (pos >= len_ext) begin
            done  <= 1'b1;
            state <= W_IDLE;
          end else begin
            state <= W_CODE;
          end
        end
        W_CODE: begin
          code <= rd_data;
          pos  <= pos + 9'd1;
          if (rd_data[7]) begin
            state <= W_LEN_RD;
          end else begin
            rlen  <= 8'd1;
            state <= W_CHECK;
          end
        end
        W_LEN_RD: begin
          if (pos >= len_ext) begin
            done  <= 1'b1;
            state <= W_IDLE;
          end else begin
            state <= W_LEN;
          end
        end
        W_LEN: begin
          rlen  <= rd_data;
          pos   <= pos + 9'd1;
          state <= W_CHECK;
        end
        W_CHECK: begin
          cnt      <= '0;
          tri_cnt  <= '0;
          band_idx <= '0;
          row_end  <= row_end_next;
          if (row_end_next > len_ext) begin
            // truncated row ends the walk
            done  <= 1'b1;
            state <= W_IDLE;
          end else begin
            case (code)
              bwpp_pkg::CODE_QUALITY, bwpp_pkg::CODE_ATTENTION,
              bwpp_pkg::CODE_MEDITATE, bwpp_pkg::CODE_BLINK: begin
                need  <= 5'd1;
                state <= W_VAL_RD;
              end
              bwpp_pkg::CODE_RAW: begin
                if (rlen >= bwpp_pkg::RAW_LEN) begin
                  need  <= 5'(bwpp_pkg::RAW_LEN);
                  state <= W_VAL_RD;
                end else begin
                  pos   <= row_end_next;
                  state <= W_CODE_RD;
                end
              end
              bwpp_pkg::CODE_POWER: begin
                if (rlen >= bwpp_pkg::POWER_LEN) begin
                  need  <= 5'(bwpp_pkg::POWER_LEN);
                  state <= W_VAL_RD;
                end else begin
                  pos   <= row_end_next;
                  state <= W_CODE_RD;
                end
              end
              default: begin
                pos   <= row_end_next;
                state <= W_CODE_RD;
              end
            endcase
          end
        end
        W_VAL_RD: begin
          state <= W_VAL;
        end
        W_VAL: begin
          acc     <= {acc[7:0], rd_data};
          cnt     <= cnt + 5'd1;
          pos     <= pos + 9'd1;
          tri_cnt <= (tri_cnt == 2'd2) ? 2'd0 : tri_cnt + 2'd1;
          if (code == bwpp_pkg::CODE_POWER && tri_cnt == 2'd2) begin
            rec.band[band_idx] <= {acc, rd_data};
            band_idx           <= band_idx + 3'd1;
          end
          if (cnt == need - 5'd1) begin
            case (code)
              bwpp_pkg::CODE_QUALITY:   rec.quality    <= rd_data;
              bwpp_pkg::CODE_ATTENTION: begin
                rec.attention <= rd_data;
                att           <= 1'b1;
              end
              bwpp_pkg::CODE_MEDITATE:  rec.meditation <= rd_data;
              bwpp_pkg::CODE_BLINK:     rec.blink      <= rd_data;
              bwpp_pkg::CODE_RAW:       rec.raw        <= {acc[7:0], rd_data};
              default: ;
            endcase
            pos   <= row_end;
            state <= W_CODE_RD;
          end else begin
            state <= W_VAL_RD;
          end
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/brainwave_sensor_packet_parser.sv =====
// Brainwave sensor packet parser.
// Input channel: in_valid/in_ready with data_byte, one serial byte per word.
// Packets are 0xAA 0xAA, a length byte (1..PAYLOAD_DEPTH), the payload and a
// checksum byte equal to the inverted 8-bit payload sum.
// Output channel: out_valid/out_ready carrying field_id, field_value,
// attention_updated and last_field. A good packet yields 13 words, ids 0..12,
// last_field set on id 12; a bad checksum yields nothing.
// Header, length and payload bytes are taken one per cycle. After the
// checksum byte the registered walk_start strobe starts a walk of the stored
// payload through a single read port of the payload memory: a row that updates
// the record reads each value byte through the registered read, a skipped row
// moves past its code byte and any length byte, and a truncated row ends the
// walk, as does the end-of-payload check. Emission then steps through the
// words on out_ready; in_ready stays low through walk and emission.
// A stalled receiver just holds the current word; the record is not touched
// until the run is taken. Reset returns to the sync hunt and clears the record
// (all fields read zero until a packet updates them); no clearing pass is run.
`include "brainwave_sensor_packet_parser_defines.svh"

module brainwave_sensor_packet_parser #(
  parameter int PAYLOAD_DEPTH = bwpp_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  field_id,
  output logic [23:0] field_value,
  output logic        attention_updated,
  output logic        last_field
);

  localparam int AW = $clog2(PAYLOAD_DEPTH);

  typedef enum logic [2:0] {
    S_HUNT1, S_HUNT2, S_LEN, S_DATA, S_SUM, S_WALK, S_EMIT
  } state_t;

  state_t            state;
  logic [7:0]        len;
  logic [7:0]        pos;
  logic [7:0]        sum;
  logic [7:0]        pos_next;
  logic [3:0]        fid;
  logic              walk_start;
  logic              walk_done;
  logic              walk_att;
  logic              in_acc;
  logic              wr_en;
  logic [3:0]        band_sel;
  bwpp_pkg::record_t rec;

  assign in_ready = (state != S_WALK) && (state != S_EMIT);
  assign in_acc   = in_valid && in_ready;
  assign wr_en    = in_acc && (state == S_DATA);
  assign pos_next = pos + 8'd1;

  bwpp_row_walker #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_walker (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (pos[AW-1:0]),
    .wr_data (data_byte),
    .start   (walk_start),
    .len     (len),
    .done    (walk_done),
    .att     (walk_att),
    .rec     (rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_HUNT1;
      len        <= '0;
      pos        <= '0;
      sum        <= '0;
      fid        <= '0;
      walk_start <= 1'b0;
    end else begin
      walk_start <= 1'b0;
      case (state)
        S_HUNT1: begin
          if (in_acc && data_byte == bwpp_pkg::SYNC_BYTE) state <= S_HUNT2;
        end
        S_HUNT2: begin
          if (in_acc) begin
            state <= (data_byte == bwpp_pkg::SYNC_BYTE) ? S_LEN : S_HUNT1;
          end
        end
        S_LEN: begin
          if (in_acc) begin
            if (data_byte == 8'd0 || 9'(data_byte) > 9'(PAYLOAD_DEPTH)) begin
              state <= S_HUNT1;
            end else begin
              len   <= data_byte;
              pos   <= '0;
              sum   <= '0;
              state <= S_DATA;
            end
          end
        end
        S_DATA: begin
          if (in_acc) begin
            pos <= pos_next;
            sum <= sum + data_byte;
            if (pos_next >= len || pos_next == 8'd0) state <= S_SUM;
          end
        end
        S_SUM: begin
          if (in_acc) begin
            if (data_byte == ~sum) begin
              walk_start <= 1'b1;
              state      <= S_WALK;
            end else begin
              state <= S_HUNT1;
            end
          end
        end
        S_WALK: begin
          if (walk_done) begin
            fid   <= bwpp_pkg::FID_QUALITY;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (fid == bwpp_pkg::FID_LAST) state <= S_HUNT1;
            else fid <= fid + 4'd1;
          end
        end
        default: state <= S_HUNT1;
      endcase
    end
  end

  assign band_sel          = fid - bwpp_pkg::FID_BAND0;
  assign out_valid         = (state == S_EMIT);
  assign field_id          = fid;
  assign attention_updated = walk_att;
  assign last_field        = (fid == bwpp_pkg::FID_LAST);

  always_comb begin
    case (fid)
      bwpp_pkg::FID_QUALITY:   field_value = 24'(rec.quality);
      bwpp_pkg::FID_ATTENTION: field_value = 24'(rec.attention);
      bwpp_pkg::FID_MEDITATE:  field_value = 24'(rec.meditation);
      bwpp_pkg::FID_BLINK:     field_value = 24'(rec.blink);
      bwpp_pkg::FID_RAW:       field_value = 24'(rec.raw);
      default:                 field_value = rec.band[band_sel[2:0]];
    endcase
  end

  `BWPP_ASSERT_SAME(a_no_overlap, out_valid, !in_ready)
  `BWPP_ASSERT_SAME(a_done_in_walk, walk_done, state == S_WALK)
  `BWPP_ASSERT_NEXT(a_run_ends, out_valid && out_ready && last_field, !out_valid && in_ready)
  `BWPP_ASSERT_NEXT(a_bad_sum, in_acc && state == S_SUM && data_byte != ~sum, !out_valid && in_ready)

endmodule

// ===== dv/tb_brainwave_sensor_packet_parser.sv =====
`timescale 1ns / 100ps

module tb_brainwave_sensor_packet_parser;
  import bwpp_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 1500;
  localparam int IDLE_PCT      = 28;
  localparam int LONG_HOLD     = 300;

  // codes the parser has no use for
  localparam logic [7:0] CODE_SPARE_SHORT = 8'h7F;
  localparam logic [7:0] CODE_SPARE_EXT   = 8'hC1;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, TAKE_LEN, TAKE_PAYLOAD, TAKE_SUM
  } parse_phase_t;

  typedef struct packed {
    logic [3:0]  id;
    logic [23:0] value;
    logic        att;
    logic        last;
  } field_word_t;

  typedef logic [7:0] byte_q_t[$];

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  field_id;
  logic [23:0] field_value;
  logic        attention_updated;
  logic        last_field;

  brainwave_sensor_packet_parser i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .data_byte         (data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .field_id          (field_id),
    .field_value       (field_value),
    .attention_updated (attention_updated),
    .last_field        (last_field)
  );

  // expected parser state
  parse_phase_t phase_q     = HUNT_FIRST;
  logic [7:0]   payload_mem [256];
  logic [7:0]   payload_len = 8'h00;
  logic [7:0]   payload_pos = 8'h00;
  logic [7:0]   payload_sum = 8'h00;
  record_t      kept_record = '0;
  field_word_t  pending_fields[$];

  int field_errors = 0;
  int cycle_count  = 0;
  int hold_asks    = 0;
  int hold_served  = 0;
  int hold_left    = 0;
  bit steady       = 1'b0;

  initial forever #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Expected behavior
  // ---------------------------------------------------------------------------

  // Applies one data row to the record; returns 1 for an attention row.
  function automatic bit apply_row(logic [7:0] code, int at, int rlen);
    case (code)
      CODE_QUALITY:   kept_record.quality = payload_mem[at];
      CODE_ATTENTION: begin
        kept_record.attention = payload_mem[at];
        return 1'b1;
      end
      CODE_MEDITATE:  kept_record.meditation = payload_mem[at];
      CODE_BLINK:     kept_record.blink = payload_mem[at];
      CODE_RAW: begin
        if (rlen >= RAW_LEN) kept_record.raw = {payload_mem[at], payload_mem[at + 1]};
      end
      CODE_POWER: begin
        if (rlen >= POWER_LEN) begin
          for (int b = 0; b < BAND_COUNT; b++)
            kept_record.band[b] = {payload_mem[at + 3 * b], payload_mem[at + 3 * b + 1],
                                   payload_mem[at + 3 * b + 2]};
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic bit walk_rows();
    int         i;
    int         rlen;
    int         len;
    logic [7:0] code;
    bit         att;
    len = payload_len;
    i   = 0;
    att = 1'b0;
    while (i < len) begin
      code = payload_mem[i];
      i++;
      if (code[7]) begin
        if (i >= len) break;
        rlen = payload_mem[i];
        i++;
      end else begin
        rlen = 1;
      end
      // a row running past the payload end stops the walk
      if (i + rlen > len) break;
      if (apply_row(code, i, rlen)) att = 1'b1;
      i += rlen;
    end
    return att;
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    bit          att;
    field_word_t w;
    case (phase_q)
      HUNT_SECOND: phase_q = (b == SYNC_BYTE) ? TAKE_LEN : HUNT_FIRST;
      TAKE_LEN: begin
        if (b == 8'h00) begin
          phase_q = HUNT_FIRST;
        end else begin
          payload_len = b;
          payload_pos = 8'h00;
          payload_sum = 8'h00;
          phase_q     = TAKE_PAYLOAD;
        end
      end
      TAKE_PAYLOAD: begin
        payload_mem[payload_pos] = b;
        payload_pos++;
        payload_sum += b;
        if (payload_pos >= payload_len || payload_pos == 8'h00) phase_q = TAKE_SUM;
      end
      TAKE_SUM: begin
        phase_q = HUNT_FIRST;
        if (b == ~payload_sum) begin
          att = walk_rows();
          for (int k = 0; k <= FID_LAST; k++) begin
            w.id   = 4'(k);
            w.att  = att;
            w.last = (w.id == FID_LAST);
            case (w.id)
              FID_QUALITY:   w.value = 24'(kept_record.quality);
              FID_ATTENTION: w.value = 24'(kept_record.attention);
              FID_MEDITATE:  w.value = 24'(kept_record.meditation);
              FID_BLINK:     w.value = 24'(kept_record.blink);
              FID_RAW:       w.value = 24'(kept_record.raw);
              default:       w.value = kept_record.band[w.id - FID_BAND0];
            endcase
            pending_fields.push_back(w);
          end
        end
      end
      default: phase_q = (b == SYNC_BYTE) ? HUNT_SECOND : HUNT_FIRST;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender, receiver, checker
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    parse_byte(b);
  endtask

  task automatic send_packet(input byte_q_t body, input bit good_sum = 1'b1);
    logic [7:0] sum;
    sum = 8'h00;
    foreach (body[i]) sum += body[i];
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'(body.size()));
    foreach (body[i]) send_byte(body[i]);
    send_byte(good_sum ? ~sum : ~sum ^ (8'h01 << $urandom_range(0, 7)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_fields.size() != 0);
  endtask

  // Appends one row; value bytes are random unless fill is given.
  function automatic void add_row(ref byte_q_t q, input logic [7:0] code, input int rlen,
                                  input int fill = -1);
    q.push_back(code);
    if (code[7]) q.push_back(8'(rlen));
    repeat (code[7] ? rlen : 1) q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
  endfunction

  always @(posedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left   <= LONG_HOLD;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      field_errors++;
      $display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    field_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_fields.size() == 0) begin
        field_errors++;
        $display("%0t unexpected word: expected none, got id %0d value %0h",
                 $time, field_id, field_value);
      end else begin
        want = pending_fields.pop_front();
        check_field("field_id", want.id, field_id);
        check_field("field_value", want.value, field_value);
        check_field("attention_updated", want.att, attention_updated);
        check_field("last_field", want.last, last_field);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[brainwave_sensor_packet_parser] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic send_random_packet(input int max_rows);
    byte_q_t body;
    int      pick;
    repeat ($urandom_range(1, max_rows)) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       add_row(body, CODE_QUALITY, 1);
        1, 2:    add_row(body, CODE_ATTENTION, 1);
        3:       add_row(body, CODE_MEDITATE, 1);
        4:       add_row(body, CODE_BLINK, 1);
        5:       add_row(body, CODE_RAW,
                         ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : RAW_LEN);
        6:       add_row(body, CODE_POWER,
                         ($urandom_range(0, 4) == 0) ? $urandom_range(22, 26) : POWER_LEN);
        7:       add_row(body, 8'($urandom_range(0, 127)), 1);
        default: add_row(body, 8'($urandom_range(128, 255)), $urandom_range(0, 4));
      endcase
    end
    // sometimes chop the tail so the last row may run past the end
    if (body.size() > 1 && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, body.size() - 1)) void'(body.pop_back());
    while (body.size() > 255) void'(body.pop_back());
    send_packet(body, $urandom_range(0, 6) != 0);
  endtask

  task automatic test_single_rows();
    byte_q_t body;
    body = '{CODE_QUALITY, 8'hFF, CODE_ATTENTION, 8'h00, CODE_MEDITATE, 8'h80,
             CODE_BLINK, 8'h7F};
    send_packet(body);
    // no attention row: flag drops, earlier values stay
    body = '{CODE_BLINK, 8'h01};
    send_packet(body);
  endtask

  task automatic test_wave_and_power();
    byte_q_t body;
    body = '{CODE_RAW, RAW_LEN, 8'h80, 8'h00};
    send_packet(body);
    // extra value bytes are ignored
    body = '{CODE_RAW, 8'd3, 8'h7F, 8'hFF, 8'h55};
    add_row(body, CODE_POWER, POWER_LEN + 1, 'h00);
    send_packet(body);
    // short rows leave the record alone
    body = '{CODE_RAW, 8'd1, 8'h12};
    add_row(body, CODE_POWER, POWER_LEN - 1, 'hA5);
    send_packet(body);
  endtask

  task automatic test_truncated_rows();
    byte_q_t body;
    body = '{CODE_QUALITY, 8'h11, CODE_ATTENTION};
    send_packet(body);
    body = '{CODE_MEDITATE, 8'h22, CODE_RAW};
    send_packet(body);
    body = '{CODE_BLINK, 8'h33, CODE_POWER, POWER_LEN, 8'h01, 8'h02, 8'h03};
    send_packet(body);
  endtask

  task automatic test_spare_codes();
    byte_q_t body;
    body = '{CODE_SPARE_SHORT, 8'h55, CODE_SPARE_EXT, 8'd3, 8'hAA, 8'hAA, 8'hAA,
             CODE_SPARE_EXT, 8'd0, CODE_QUALITY, 8'h44};
    send_packet(body);
  endtask

  task automatic test_framing();
    byte_q_t body;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_BYTE);
    send_byte(8'h55);
    // zero length drops back to the hunt
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'h00);
    body = '{CODE_ATTENTION, 8'hEE, CODE_QUALITY, 8'h99};
    send_packet(body, 1'b0);
    body = '{CODE_MEDITATE, 8'h66};
    send_packet(body);
  endtask

  // A 170-byte payload puts a third sync value in the length slot; sent with
  // no idling on either side.
  task automatic test_long_payloads();
    byte_q_t body;
    steady = 1'b1;
    while (body.size() < 170) add_row(body, CODE_POWER, POWER_LEN);
    while (body.size() > 170) void'(body.pop_back());
    send_packet(body);
    wait_drained();
    steady = 1'b0;
  endtask

  task automatic test_back_pressure();
    hold_asks++;
    steady = 1'b1;
    repeat (3) send_random_packet(4);
    wait_drained();
    steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_single_rows();
    test_wave_and_power();
    test_truncated_rows();
    test_spare_codes();
    test_framing();
    wait_drained();
    test_long_payloads();
    test_back_pressure();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (field_errors == 0) begin
      $display("[brainwave_sensor_packet_parser] OK");
    end else begin
      $display("[brainwave_sensor_packet_parser] ERROR");
    end
    $finish;
  end

endmodule
